>>> src/cast_pkg.sv
// Shared types, constants and codes of the cadence-aware staleness taper.
// No dependencies; every other file imports this package.
package cast_pkg;

  localparam int STAMP_BITS_DEF    = 48;
  localparam int INTERVAL_BITS_DEF = 24;

  localparam int TIME_W    = 24;  // microsecond registers and window fields
  localparam int FRAC_W    = 16;  // Q0.16 / Q8.8 coefficients, Q1.15 factor
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;
  localparam int OP_W      = 2;
  localparam int DIV_STEPS = 16;  // quotient bits of the taper factor

  localparam logic [FRAC_W-1:0] Q15_ONE = 16'h8000;

  // Opcodes
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_W-1:0] OP_FORGET = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OUT_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CADENCE_AWARE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CADENCE_FACTOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CADENCE_CAP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING      = 3'd7;

  // Register reset values
  localparam logic [TIME_W-1:0] RST_PHASE_OUT_TIME = 24'd1000000;
  localparam logic [TIME_W-1:0] RST_MAX_TIME       = 24'd3000000;
  localparam logic              RST_CADENCE_AWARE  = 1'b1;
  localparam logic [FRAC_W-1:0] RST_CADENCE_FACTOR = 16'd768;
  localparam logic [TIME_W-1:0] RST_CADENCE_CAP    = 24'd3000000;
  localparam logic [TIME_W-1:0] RST_MIN_INTERVAL   = 24'd20000;
  localparam logic [TIME_W-1:0] RST_MAX_INTERVAL   = 24'd10000000;
  localparam logic [FRAC_W-1:0] RST_SMOOTHING      = 16'd16384;

  typedef struct packed {
    logic [TIME_W-1:0] phase_out_time;
    logic [TIME_W-1:0] max_time;
    logic              cadence_aware;
    logic [FRAC_W-1:0] cadence_factor;
    logic [TIME_W-1:0] cadence_cap;
    logic [TIME_W-1:0] min_interval;
    logic [TIME_W-1:0] max_interval;
    logic [FRAC_W-1:0] smoothing;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_BMUL,
    ST_BWR,
    ST_SMUL,
    ST_CLAMP,
    ST_END,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic upd;
    logic bmul;
    logic bwr;
    logic smul;
    logic clamp;
    logic fin_end;
    logic prep;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_update;
    logic div_go;
    logic out_busy;
  } stat_t;

endpackage

>>> src/cast_if.sv
// Request and response channel interfaces of the staleness taper.
// Depends on cast_pkg.
interface cast_req_if import cast_pkg::*; #(
  parameter int STAMP_BITS = STAMP_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       opcode;
  logic [STAMP_BITS-1:0] timestamp;
  logic [TIME_W-1:0]     elapsed;

  modport source (output valid, opcode, timestamp, elapsed, input ready);
  modport sink   (input valid, opcode, timestamp, elapsed, output ready);
endinterface

interface cast_rsp_if import cast_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FRAC_W-1:0] taper_factor;
  logic [TIME_W-1:0] window_start;
  logic [TIME_W-1:0] window_end;
  logic              tapering;
  logic              has_cadence;

  modport source (output valid, taper_factor, window_start, window_end, tapering,
                  has_cadence, input ready);
  modport sink   (input valid, taper_factor, window_start, window_end, tapering,
                  has_cadence, output ready);
endinterface

>>> src/cast_ctrl.sv
// Sequencer of the staleness taper: steps the datapath through one word.
// Depends on cast_pkg.
module cast_ctrl import cast_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (cmd.prep) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (req_valid) state_next = ST_UPD;
      ST_UPD:   state_next = stat.is_update ? ST_BMUL : ST_SMUL;
      ST_BMUL:  state_next = ST_BWR;
      ST_BWR:   state_next = ST_SMUL;
      ST_SMUL:  state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_END;
      ST_END:   state_next = ST_PREP;
      ST_PREP:  state_next = stat.div_go ? ST_DIV : ST_OUT;
      ST_DIV:   if (cnt == CNT_LAST) state_next = ST_OUT;
      ST_OUT:   if (!stat.out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_UPD:   cmd.upd      = 1'b1;
      ST_BMUL:  cmd.bmul     = 1'b1;
      ST_BWR:   cmd.bwr      = 1'b1;
      ST_SMUL:  cmd.smul     = 1'b1;
      ST_CLAMP: cmd.clamp    = 1'b1;
      ST_END:   cmd.fin_end  = 1'b1;
      ST_PREP:  cmd.prep     = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_OUT:   cmd.out_load = !stat.out_busy;
      default: begin
        cmd       = '0;
        req_ready = 1'b0;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_UPD))
    else $error("accepted word did not start the update step");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && cnt == CNT_LAST) |=> (state == ST_OUT))
    else $error("divider did not finish after its last step");

  a_prep_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP && stat.div_go) |=> (state == ST_DIV && cnt == '0))
    else $error("divider entered with a stale step count");

endmodule

>>> src/cast_dp.sv
// Datapath of the staleness taper: cadence state, shared multiplier,
// window logic, radix-2 divider and the result register. Depends on cast_pkg.
module cast_dp import cast_pkg::*; #(
  parameter int STAMP_BITS    = STAMP_BITS_DEF,
  parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [OP_W-1:0]       req_opcode,
  input  logic [STAMP_BITS-1:0] req_timestamp,
  input  logic [TIME_W-1:0]     req_elapsed,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [FRAC_W-1:0]     out_taper_factor,
  output logic [TIME_W-1:0]     out_window_start,
  output logic [TIME_W-1:0]     out_window_end,
  output logic                  out_tapering,
  output logic                  out_has_cadence
);

  localparam int LW  = (INTERVAL_BITS > TIME_W) ? INTERVAL_BITS : TIME_W;
  localparam int MW  = LW + 1;            // signed multiplier operand
  localparam int PW  = MW + FRAC_W + 1;   // signed product
  localparam int SRW = PW - 7;            // rounded scaled start
  localparam int NW  = TIME_W + FRAC_W;   // divider numerator

  // Latched word
  logic [OP_W-1:0]          op_r;
  logic [STAMP_BITS-1:0]    ts_r;
  logic [TIME_W-1:0]        el_r;
  // Cadence state
  logic [STAMP_BITS-1:0]    last_stamp;
  logic [INTERVAL_BITS-1:0] interval;
  // Work registers
  logic [LW-1:0]            gap_r;
  logic                     gap_ok;
  logic signed [PW-1:0]     prod;
  logic [TIME_W-1:0]        start_r, end_r;
  logic                     scaled_r;
  logic                     taper_on;
  logic [FRAC_W-1:0]        fac_r;
  logic [TIME_W-1:0]        div_d, rem_r;
  logic [FRAC_W-1:0]        nlo;

  // Update step
  logic [STAMP_BITS-1:0] gap_full;
  logic                  fwd, in_bounds;
  assign gap_full  = ts_r - last_stamp;
  assign fwd       = (last_stamp != '0) && (ts_r >= last_stamp);
  assign in_bounds = (gap_full >= STAMP_BITS'(cfg.min_interval)) &&
                     (gap_full <= STAMP_BITS'(cfg.max_interval));

  // Shared multiplier: blend delta times smoothing, or interval times factor
  logic [LW-1:0]          iv_ext;
  logic signed [MW-1:0]   mul_a;
  logic signed [FRAC_W:0] mul_b;
  assign iv_ext = LW'(interval);
  always_comb begin
    if (cmd.smul) begin
      mul_a = $signed({1'b0, iv_ext});
      mul_b = $signed({1'b0, cfg.cadence_factor});
    end else begin
      mul_a = $signed({1'b0, gap_r}) - $signed({1'b0, iv_ext});
      mul_b = $signed({1'b0, cfg.smoothing});
    end
  end

  // Blend: old + (gap - old) * w, rounded, saturated
  logic signed [PW-1:0] bsum, rnd_half;
  logic [LW+1:0]        bv, v_full;
  assign rnd_half = PW'(32'sd32768);
  assign bsum     = $signed({2'b00, iv_ext, {FRAC_W{1'b0}}}) + prod + rnd_half;
  assign bv       = bsum[PW-1:FRAC_W];
  assign v_full   = (interval == '0) ? (LW+2)'(gap_r) : bv;

  // Scaled window start
  logic [PW:0]         sr_sum;
  logic [SRW-1:0]      sr;
  logic [TIME_W-1:0]   ceil_t, s_clamp;
  assign sr_sum = {1'b0, $unsigned(prod)} + (PW+1)'(128);
  assign sr     = sr_sum[PW:8];
  assign ceil_t = (cfg.cadence_cap > cfg.phase_out_time) ? cfg.cadence_cap
                                                         : cfg.phase_out_time;
  always_comb begin
    if (sr < SRW'(cfg.phase_out_time)) begin
      s_clamp = cfg.phase_out_time;
    end else if (sr > SRW'(ceil_t)) begin
      s_clamp = ceil_t;
    end else begin
      s_clamp = sr[TIME_W-1:0];
    end
  end

  // Window end of the scaled case
  logic [TIME_W-1:0] taper_len, e_sat, e_fin;
  logic [TIME_W:0]   e_sum;
  assign taper_len = (cfg.max_time > cfg.phase_out_time) ?
                     cfg.max_time - cfg.phase_out_time : '0;
  assign e_sum     = {1'b0, start_r} + {1'b0, taper_len};
  assign e_sat     = e_sum[TIME_W] ? '1 : e_sum[TIME_W-1:0];
  assign e_fin     = (cfg.max_time > e_sat) ? cfg.max_time : e_sat;

  // Factor setup
  logic              tap, past_start, past_end;
  logic [TIME_W-1:0] d_w, left_w;
  logic [NW-1:0]     num;
  assign tap        = end_r > start_r;
  assign past_start = el_r > start_r;
  assign past_end   = el_r >= end_r;
  assign d_w        = end_r - start_r;
  assign left_w     = end_r - el_r;
  assign num        = {1'b0, left_w, {(FRAC_W-1){1'b0}}} + NW'(d_w[TIME_W-1:1]);

  // Divider step
  logic [TIME_W:0] rs, rs_sub;
  logic            ge;
  assign rs     = {rem_r, nlo[FRAC_W-1]};
  assign ge     = rs >= {1'b0, div_d};
  assign rs_sub = rs - {1'b0, div_d};

  assign stat.is_update = (op_r == OP_UPDATE);
  assign stat.div_go    = (op_r == OP_QUERY) && tap && past_start && !past_end;
  assign stat.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp <= '0;
      interval   <= '0;
    end else if (cmd.upd) begin
      unique case (op_r)
        OP_UPDATE: last_stamp <= ts_r;
        OP_FORGET: begin
          last_stamp <= '0;
          interval   <= '0;
        end
        default: ;
      endcase
    end else if (cmd.bwr && gap_ok) begin
      interval <= (|v_full[LW+1:INTERVAL_BITS]) ? '1 : v_full[INTERVAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= req_opcode;
      ts_r <= req_timestamp;
      el_r <= req_elapsed;
    end
    if (cmd.upd) begin
      gap_ok <= (op_r == OP_UPDATE) && fwd && in_bounds;
      gap_r  <= gap_full[LW-1:0];
    end
    if (cmd.bmul || cmd.smul) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.clamp) begin
      scaled_r <= 1'b0;
      if (cfg.max_time == '0 || cfg.phase_out_time == '0) begin
        start_r <= '0;
        end_r   <= '0;
      end else if (!cfg.cadence_aware) begin
        start_r <= cfg.phase_out_time;
        end_r   <= (cfg.max_time > cfg.phase_out_time) ? cfg.max_time
                                                       : cfg.phase_out_time;
      end else if (interval == '0) begin
        start_r <= '0;
        end_r   <= '0;
      end else begin
        start_r  <= s_clamp;
        scaled_r <= 1'b1;
      end
    end
    if (cmd.fin_end && scaled_r) begin
      end_r <= e_fin;
    end
    if (cmd.prep) begin
      taper_on <= tap;
      div_d    <= d_w;
      rem_r    <= num[NW-1:FRAC_W];
      nlo      <= num[FRAC_W-1:0];
      fac_r    <= ((op_r == OP_QUERY) && tap && past_start) ? '0 : Q15_ONE;
    end
    if (cmd.div_step) begin
      rem_r <= ge ? rs_sub[TIME_W-1:0] : rs[TIME_W-1:0];
      nlo   <= {nlo[FRAC_W-2:0], 1'b0};
      fac_r <= {fac_r[FRAC_W-2:0], ge};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_taper_factor <= fac_r;
      out_window_start <= taper_on ? start_r : '0;
      out_window_end   <= taper_on ? end_r : '0;
      out_tapering     <= taper_on;
      out_has_cadence  <= (interval != '0);
    end
  end

  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_taper_factor <= Q15_ONE))
    else $error("taper factor above one");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem_r < div_d))
    else $error("divider remainder not below divisor");

  a_forget_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.upd && op_r == OP_FORGET) |=> (interval == '0 && last_stamp == '0))
    else $error("forget left cadence state behind");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_tapering) |-> (out_window_end > out_window_start))
    else $error("tapering window is empty");

endmodule

>>> src/cadence_aware_staleness_taper_unit.sv
// Top level of the cadence-aware staleness taper: register bank, sequencer
// and datapath. Depends on cast_pkg, cast_if, cast_ctrl and cast_dp.
//
// Use: req carries one word per operation: opcode 0 notes an update at
// timestamp (microseconds), opcode 1 forgets the measured cadence, opcode 2
// asks for the taper factor at elapsed microseconds since the last update.
// Every word yields exactly one word on rsp: the Q1.15 taper factor, the
// taper window and the tapering / has_cadence flags after the operation.
// Configuration goes in through cfg_we / cfg_index / cfg_data, one register
// per cycle, while no word is in flight.
//
// Sequencing: the sequencer works one word at a time. After acceptance, forget,
// opcode 3 and queries that need no division pass the update, scaled multiply,
// clamp, window-end and prepare steps before the result is loaded; updates add
// the blend multiply and write-back, and a query inside the window adds the
// radix-2 divider, which retires one quotient bit per cycle. req.ready rises
// again the cycle after the result is loaded, so the block takes no new word
// until the last one is through.
// Reset (synchronous, rst high) restores the register defaults and clears
// the last timestamp and the smoothed interval. A stalled rsp holds its word
// in the result register; the next word is still taken and runs until its
// own result is ready, then waits in place until the register frees up.
module cadence_aware_staleness_taper_unit import cast_pkg::*; #(
  parameter int STAMP_BITS    = STAMP_BITS_DEF,
  parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  cast_req_if.sink             req,
  cast_rsp_if.source           rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // Register bank: take each write at once, masked to the register width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_out_time <= RST_PHASE_OUT_TIME;
      cfg.max_time       <= RST_MAX_TIME;
      cfg.cadence_aware  <= RST_CADENCE_AWARE;
      cfg.cadence_factor <= RST_CADENCE_FACTOR;
      cfg.cadence_cap    <= RST_CADENCE_CAP;
      cfg.min_interval   <= RST_MIN_INTERVAL;
      cfg.max_interval   <= RST_MAX_INTERVAL;
      cfg.smoothing      <= RST_SMOOTHING;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PHASE_OUT_TIME: cfg.phase_out_time <= cfg_data[TIME_W-1:0];
        CFG_MAX_TIME:       cfg.max_time       <= cfg_data[TIME_W-1:0];
        CFG_CADENCE_AWARE:  cfg.cadence_aware  <= cfg_data[0];
        CFG_CADENCE_FACTOR: cfg.cadence_factor <= cfg_data[FRAC_W-1:0];
        CFG_CADENCE_CAP:    cfg.cadence_cap    <= cfg_data[TIME_W-1:0];
        CFG_MIN_INTERVAL:   cfg.min_interval   <= cfg_data[TIME_W-1:0];
        CFG_MAX_INTERVAL:   cfg.max_interval   <= cfg_data[TIME_W-1:0];
        CFG_SMOOTHING:      cfg.smoothing      <= cfg_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: holds req.ready high only between words
  cast_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: cadence state, window math, divider and result register
  cast_dp #(
    .STAMP_BITS    (STAMP_BITS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .stat             (stat),
    .req_opcode       (req.opcode),
    .req_timestamp    (req.timestamp),
    .req_elapsed      (req.elapsed),
    .out_ready        (rsp.ready),
    .out_valid        (rsp.valid),
    .out_taper_factor (rsp.taper_factor),
    .out_window_start (rsp.window_start),
    .out_window_end   (rsp.window_end),
    .out_tapering     (rsp.tapering),
    .out_has_cadence  (rsp.has_cadence)
  );

endmodule
